/* hw/rtl/dfcs_pkg.sv */
// dfcs_pkg: shared types, register offsets and byte rules of the disk controller
// configuration space; used by the top level dual_function_ide_pci_config_space_core
// no dependencies
package dfcs_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned FnDepth = 256;  // bytes of one function's space

  // register offsets with special handling
  localparam logic [7:0] OFF_CMD       = 8'h04;
  localparam logic [7:0] OFF_CMD_HI    = 8'h05;
  localparam logic [7:0] OFF_STATUS_HI = 8'h07;
  localparam logic [7:0] OFF_CMDB_LO   = 8'h10;
  localparam logic [7:0] OFF_CMDB_HI   = 8'h11;
  localparam logic [7:0] OFF_CTLP_LO   = 8'h14;
  localparam logic [7:0] OFF_CTLP_HI   = 8'h15;
  localparam logic [7:0] OFF_DMAB_LO   = 8'h20;
  localparam logic [7:0] OFF_DMAB_HI   = 8'h21;
  localparam logic [7:0] OFF_ROM_0     = 8'h30;
  localparam logic [7:0] OFF_ROM_2     = 8'h32;
  localparam logic [7:0] OFF_ROM_3     = 8'h33;
  localparam logic [7:0] OFF_IRQ_PIN   = 8'h3d;
  localparam logic [7:0] OFF_CHAN_EN   = 8'h50;
  localparam logic [7:0] OFF_TIMING    = 8'h51;

  localparam logic [0:0] OP_READ  = 1'b0;
  localparam logic [0:0] OP_WRITE = 1'b1;

  typedef enum logic [0:0] {
    ST_INIT,
    ST_RUN
  } dfcs_state_e;

  // one accepted transaction
  typedef struct packed {
    logic [0:0] opcode;
    logic [2:0] function_number;
    logic [7:0] offset;
    logic [7:0] write_byte;
  } dfcs_item_t;

  // outcome of the write rules for one byte
  typedef struct packed {
    logic       we;
    logic       shared;
    logic [7:0] val;
  } dfcs_wr_t;

  // decode-relevant bytes of one function kept beside the memory
  typedef struct packed {
    logic [7:0] cmd;
    logic [7:0] cmdb_lo;
    logic [7:0] cmdb_hi;
    logic [7:0] ctlp_lo;
    logic [7:0] ctlp_hi;
    logic [7:0] dmab_hi;
  } dfcs_shadow_t;

  localparam dfcs_shadow_t SHADOW_RST = '{
    cmd: 8'h00, cmdb_lo: 8'h01, cmdb_hi: 8'h00,
    ctlp_lo: 8'h01, ctlp_hi: 8'h00, dmab_hi: 8'h00
  };
  localparam logic [7:0] CHAN_EN_RST = 8'h30;

  // power-on contents of one byte
  function automatic logic [7:0] reset_byte(input logic fn1, input logic [7:0] off);
    logic [7:0] b;
    b = 8'h00;
    case (off) inside
      8'h00:         b = 8'h03;
      8'h01:         b = 8'h11;
      8'h02:         b = 8'h04;
      OFF_STATUS_HI: b = 8'h02;
      8'h08:         b = 8'h01;
      8'h0a:         b = 8'h80;
      8'h0b:         b = 8'h01;
      8'h0e:         b = 8'h80;
      OFF_CMDB_LO:   b = 8'h01;
      OFF_CTLP_LO:   b = 8'h01;
      OFF_DMAB_LO:   b = 8'h01;
      8'h2c:         b = 8'h03;
      8'h2d:         b = 8'h11;
      8'h2e:         b = 8'h04;
      OFF_IRQ_PIN:   b = fn1 ? 8'h02 : 8'h01;
      8'h40, 8'h41, 8'h44, 8'h45: b = 8'ha7;
      8'h42, 8'h46:  b = 8'h20;
      8'h43, 8'h47:  b = 8'h01;
      OFF_CHAN_EN:   b = CHAN_EN_RST;
      default:       b = 8'h00;
    endcase
    return b;
  endfunction

  // per-offset write rules: masks, forced bits, write-one-to-clear, shared bytes
  function automatic dfcs_wr_t write_rule(input logic fn1, input logic [7:0] off,
                                          input logic [7:0] v, input logic [7:0] old);
    dfcs_wr_t r;
    r.we     = 1'b1;
    r.shared = 1'b0;
    r.val    = v;
    case (off) inside
      OFF_CMD:       r.val = v & 8'h07;
      OFF_CMD_HI:    r.val = v & 8'h01;
      OFF_STATUS_HI: r.val = old & ~(v & 8'hb8);
      OFF_CMDB_LO:   r.val = (v & 8'hf8) | 8'h01;
      OFF_CTLP_LO:   r.val = (v & 8'hfc) | 8'h01;
      OFF_DMAB_LO:   r.val = 8'h01;
      8'h0d, [8'h11:8'h13], [8'h15:8'h17], [8'h21:8'h23], [8'h28:8'h2f], 8'h3c,
      [8'h40:8'h4f], [8'h5b:8'hff]: r.val = v;
      OFF_ROM_0: begin
        r.we  = ~fn1;
        r.val = v & 8'h01;
      end
      OFF_ROM_2: begin
        r.we  = ~fn1;
        r.val = v & 8'hfe;
      end
      OFF_ROM_3:     r.we = ~fn1;
      OFF_CHAN_EN: begin
        r.shared = 1'b1;
        r.val    = v & 8'hf3;
      end
      OFF_TIMING: begin
        r.shared = 1'b1;
        r.val    = v & 8'hf0;
      end
      [8'h52:8'h5a]: r.shared = 1'b1;
      default:       r.we = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/dfcs_ram.sv */
// dfcs_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
module dfcs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/dual_function_ide_pci_config_space_core.sv */
// dual_function_ide_pci_config_space_core: configuration space of a two-function
// disk controller; depends on dfcs_pkg and dfcs_ram
//
// usage
//  - s_axis carries one byte access per transaction: tuser is the opcode (0 read,
//    1 write), tdata holds function number, offset and write data
//  - m_axis returns one result per access: the read byte and the port decodes of
//    the addressed function as they stand after the access
//  - cfg_we_i/cfg_wdata_i write the onboard enable; write it only while idle
//  - an access goes through the write-back stage and the output register to m_axis
//  - throughput: one access per cycle while m_axis_tready stays high; each access reads
//    its byte from the per-function ram at acceptance and writes it back when it
//    leaves the write-back stage; a one-entry forward register covers a read of the
//    byte being written back; after reset both rams are loaded with their power-on
//    contents, one offset of both functions per cycle for all 256 offsets, with s_axis_tready low meanwhile
//  - when m_axis_tready is low the result waits in the output register; one
//    more access can be held in the write-back stage, then tready drops
//  - a function number above 1 reads 0xff, ignores writes and decodes to zero
module dual_function_ide_pci_config_space_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration register
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,      // onboard_enable
  // access stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,     // function_number[2:0], offset[10:3],
                                        // write_byte[18:11], zero fill
  input  logic        s_axis_tuser,     // opcode
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata      // read_byte[7:0], command_base[23:8],
                                        // control_port[39:24], channel_decode_on[40],
                                        // dma_base[56:41], dma_decode_on[57], zero fill
);
  import dfcs_pkg::*;

  localparam int unsigned AddrW = $clog2(FnDepth);

  // init sweep control
  dfcs_state_e      st_q, st_d;
  logic [AddrW-1:0] init_cnt_q, init_cnt_d;
  logic             init_last;

  // configuration register
  logic onboard_q;

  // write-back stage
  dfcs_item_t s1_q;
  logic       s1_vld_q, s1_vld_d;
  logic       s1_adv;
  logic       in_accept;

  // ram ports
  logic             ram_we [2];
  logic [7:0]       ram_wd [2];
  logic [7:0]       ram_rd [2];
  logic [AddrW-1:0] ram_wa;

  // forward register for the last written byte
  logic       fwd_vld_q;
  logic [7:0] fwd_off_q;
  logic [7:0] fwd_data_q;
  logic [1:0] fwd_mask_q;

  // decode shadows
  dfcs_shadow_t sh_q [2];
  dfcs_shadow_t sh_d [2];
  logic [7:0]   chan_en_q, chan_en_d;

  // access evaluation
  logic         fn_sel;
  logic         fn_absent;
  logic [7:0]   old_byte;
  dfcs_wr_t     wr;
  logic         do_wr;
  dfcs_shadow_t cur;
  logic [15:0]  cmdb, ctlp, dmab;
  logic         chon, dmon;
  logic [7:0]   rd_byte;
  logic [63:0]  result;

  // output register
  logic        m_vld_q, m_vld_d;
  logic [63:0] m_data_q;

  // ---------------------------------------------------------------- init fsm
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_INIT;
      init_cnt_q <= '0;
    end else begin
      st_q       <= st_d;
      init_cnt_q <= init_cnt_d;
    end
  end

  always_comb begin
    st_d       = st_q;
    init_cnt_d = init_cnt_q;
    init_last  = (init_cnt_q == AddrW'(FnDepth - 1));
    case (st_q)
      ST_INIT: begin
        init_cnt_d = init_cnt_q + AddrW'(1);
        if (init_last) begin
          st_d = ST_RUN;
        end
      end
      ST_RUN:  st_d = ST_RUN;
      default: st_d = ST_INIT;
    endcase
  end

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      onboard_q <= 1'b1;
    end else if (cfg_we_i) begin
      onboard_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------- handshake
  assign s1_adv        = s1_vld_q && (!m_vld_q || m_axis_tready);
  assign s_axis_tready = (st_q == ST_RUN) && (!s1_vld_q || s1_adv);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_accept) begin
      s1_vld_d = 1'b1;
    end else if (s1_adv) begin
      s1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
    end
  end

  // payload of the accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q.opcode          <= s_axis_tuser;
      s1_q.function_number <= s_axis_tdata[2:0];
      s1_q.offset          <= s_axis_tdata[10:3];
      s1_q.write_byte      <= s_axis_tdata[18:11];
    end
  end

  // ---------------------------------------------------------------- rams
  // one ram per function so shared bytes update both in the same cycle
  for (genvar f = 0; f < 2; f++) begin : g_fn
    dfcs_ram #(
      .Width (ByteW),
      .Depth (FnDepth)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[f]),
      .waddr_i (ram_wa),
      .wdata_i (ram_wd[f]),
      .re_i    (in_accept),
      .raddr_i (s_axis_tdata[10:3]),
      .rdata_o (ram_rd[f])
    );
  end

  // ---------------------------------------------------------------- access
  assign fn_sel    = s1_q.function_number[0];
  assign fn_absent = (s1_q.function_number[2:1] != 2'b00);

  // a byte written back at the edge of our read comes from the forward register
  assign old_byte = (fwd_vld_q && (fwd_off_q == s1_q.offset) && fwd_mask_q[fn_sel])
                    ? fwd_data_q : ram_rd[fn_sel];

  assign wr    = write_rule(fn_sel, s1_q.offset, s1_q.write_byte, old_byte);
  assign do_wr = s1_adv && (s1_q.opcode == OP_WRITE) && !fn_absent && wr.we;

  always_comb begin
    if (st_q == ST_INIT) begin
      ram_wa    = init_cnt_q;
      ram_we[0] = 1'b1;
      ram_we[1] = 1'b1;
      ram_wd[0] = reset_byte(1'b0, init_cnt_q);
      ram_wd[1] = reset_byte(1'b1, init_cnt_q);
    end else begin
      ram_wa    = s1_q.offset;
      ram_we[0] = do_wr && (!fn_sel || wr.shared);
      ram_we[1] = do_wr && (fn_sel || wr.shared);
      ram_wd[0] = wr.val;
      ram_wd[1] = wr.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else if (do_wr) begin
      fwd_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      fwd_off_q  <= s1_q.offset;
      fwd_data_q <= wr.val;
      fwd_mask_q <= {ram_we[1], ram_we[0]};
    end
  end

  // shadows follow every write so decodes need no extra ram ports
  always_comb begin
    sh_d[0]   = sh_q[0];
    sh_d[1]   = sh_q[1];
    chan_en_d = chan_en_q;
    if (do_wr) begin
      case (s1_q.offset)
        OFF_CMD:     sh_d[fn_sel].cmd     = wr.val;
        OFF_CMDB_LO: sh_d[fn_sel].cmdb_lo = wr.val;
        OFF_CMDB_HI: sh_d[fn_sel].cmdb_hi = wr.val;
        OFF_CTLP_LO: sh_d[fn_sel].ctlp_lo = wr.val;
        OFF_CTLP_HI: sh_d[fn_sel].ctlp_hi = wr.val;
        OFF_DMAB_HI: sh_d[fn_sel].dmab_hi = wr.val;
        OFF_CHAN_EN: chan_en_d            = wr.val;
        default:     chan_en_d            = chan_en_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_q[0]   <= SHADOW_RST;
      sh_q[1]   <= SHADOW_RST;
      chan_en_q <= CHAN_EN_RST;
    end else begin
      sh_q[0]   <= sh_d[0];
      sh_q[1]   <= sh_d[1];
      chan_en_q <= chan_en_d;
    end
  end

  // decodes of the addressed function after the access
  assign cur  = sh_d[fn_sel];
  assign cmdb = {cur.cmdb_hi, cur.cmdb_lo & 8'hf8};
  assign ctlp = {cur.ctlp_hi, cur.ctlp_lo & 8'hfc} + 16'd2;
  assign dmab = {cur.dmab_hi, 8'h00};
  // channel bit: bit 4 for function 0, bit 5 for function 1
  assign chon = onboard_q && chan_en_d[{2'b10, fn_sel}] && cur.cmd[0] &&
                (cmdb != 16'd0) && (ctlp != 16'd0);
  assign dmon = onboard_q && cur.cmd[0] && cur.cmd[2];

  always_comb begin
    if (fn_absent) begin
      rd_byte = (s1_q.opcode == OP_READ) ? 8'hff : 8'h00;
      result  = {56'd0, rd_byte};
    end else begin
      rd_byte = (s1_q.opcode == OP_READ) ? old_byte : 8'h00;
      result  = {6'd0, dmon, dmab, chon, ctlp, cmdb, rd_byte};
    end
  end

  // ---------------------------------------------------------------- output
  always_comb begin
    m_vld_d = m_vld_q;
    if (s1_adv) begin
      m_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      m_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      m_data_q <= result;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;

  // ---------------------------------------------------------------- checks
  // no access may reach the rams while they are being loaded
  a_no_accept_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> st_q == ST_RUN)
    else $error("access accepted during ram load");

  // function 1 never writes the rom window bytes
  a_fn1_rom_ro: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RUN) && ram_we[1] |->
      !(ram_wa == OFF_ROM_0 || ram_wa == 8'h31 || ram_wa == OFF_ROM_2 ||
        ram_wa == OFF_ROM_3))
    else $error("function 1 wrote a read-only rom byte");

  // shared bytes land in both functions with the same value
  a_shared_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RUN) && (ram_we[0] || ram_we[1]) && wr.shared |->
      ram_we[0] && ram_we[1] && (ram_wd[0] == ram_wd[1]))
    else $error("shared byte written into one function only");

  // a new result only follows a transaction in the write-back stage
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_vld_q) |-> $past(s1_vld_q))
    else $error("result without a transaction");

endmodule

/* tb/dual_function_ide_pci_config_space_core_test.sv */
// self-checking testbench for dual_function_ide_pci_config_space_core: a byte-access
// predictor of both functions' configuration space checks every result transaction
// depends on dfcs_pkg and the core; no files, no arguments
module dual_function_ide_pci_config_space_core_test;
  import dfcs_pkg::*;

  localparam int unsigned LimitCycles = 200000;
  localparam int unsigned MaxShown    = 10;
  localparam int unsigned HoldCycles  = 160;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [15:0] command_base;
    logic [15:0] control_port;
    logic        channel_decode_on;
    logic [15:0] dma_base;
    logic        dma_decode_on;
  } decode_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;

  dual_function_ide_pci_config_space_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // predicted configuration space, index {function bit, offset}
  logic [7:0] space_img [0:511];
  logic       onboard_en;

  dfcs_item_t     access_q[$];
  decode_result_t due_results[$];

  int unsigned err_cnt    = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned idle_odds  = 0;  // 1 in idle_odds chance of an idle burst, 0 = none
  int unsigned send_gap   = 0;
  int unsigned recv_stall = 0;
  int unsigned hold_left  = 0;
  bit          hold_armed = 1'b0;
  bit          accepted   = 1'b0;

  // one access against the predicted space; decodes are taken after the access
  function automatic decode_result_t cfgspace_access(dfcs_item_t a);
    decode_result_t r;
    logic           fn1;
    logic [7:0]     ofs;
    logic [7:0]     v;
    logic [7:0]     cmd;
    r = '0;
    if (a.function_number > 3'd1) begin
      if (a.opcode == OP_READ) r.read_byte = 8'hff;
      return r;
    end
    fn1 = a.function_number[0];
    ofs = a.offset;
    v   = a.write_byte;
    if (a.opcode == OP_READ) begin
      r.read_byte = space_img[{fn1, ofs}];
    end else begin
      case (ofs)
        OFF_CMD:       space_img[{fn1, ofs}] = v & 8'h07;
        OFF_CMD_HI:    space_img[{fn1, ofs}] = v & 8'h01;
        OFF_STATUS_HI: space_img[{fn1, ofs}] = space_img[{fn1, ofs}] & ~(v & 8'hb8);
        OFF_CMDB_LO:   space_img[{fn1, ofs}] = (v & 8'hf8) | 8'h01;
        OFF_CTLP_LO:   space_img[{fn1, ofs}] = (v & 8'hfc) | 8'h01;
        OFF_DMAB_LO:   space_img[{fn1, ofs}] = 8'h01;
        // expansion rom bytes live in function 0 only
        OFF_ROM_0:     if (!fn1) space_img[{1'b0, ofs}] = v & 8'h01;
        OFF_ROM_2:     if (!fn1) space_img[{1'b0, ofs}] = v & 8'hfe;
        OFF_ROM_3:     if (!fn1) space_img[{1'b0, ofs}] = v;
        OFF_CHAN_EN: begin
          space_img[{1'b0, ofs}] = v & 8'hf3;
          space_img[{1'b1, ofs}] = v & 8'hf3;
        end
        OFF_TIMING: begin
          space_img[{1'b0, ofs}] = v & 8'hf0;
          space_img[{1'b1, ofs}] = v & 8'hf0;
        end
        default: begin
          if (ofs == 8'h0d || (ofs >= 8'h11 && ofs <= 8'h13) ||
              (ofs >= 8'h15 && ofs <= 8'h17) || (ofs >= 8'h21 && ofs <= 8'h23) ||
              (ofs >= 8'h28 && ofs <= 8'h2f) || ofs == 8'h3c ||
              (ofs >= 8'h40 && ofs <= 8'h4f) || ofs >= 8'h5b) begin
            space_img[{fn1, ofs}] = v;
          end else if (ofs >= 8'h52 && ofs <= 8'h5a) begin
            space_img[{1'b0, ofs}] = v;
            space_img[{1'b1, ofs}] = v;
          end
        end
      endcase
    end
    cmd = space_img[{fn1, OFF_CMD}];
    r.command_base = {space_img[{fn1, OFF_CMDB_HI}], space_img[{fn1, OFF_CMDB_LO}] & 8'hf8};
    r.control_port = {space_img[{fn1, OFF_CTLP_HI}], space_img[{fn1, OFF_CTLP_LO}] & 8'hfc}
                     + 16'd2;
    // channel enable bits sit in function 0's copy: bit 4 for fn 0, bit 5 for fn 1
    r.channel_decode_on = onboard_en &&
                          ((space_img[{1'b0, OFF_CHAN_EN}] & (8'h10 << fn1)) != 8'h00) &&
                          cmd[0] && r.command_base != 16'h0000 &&
                          r.control_port != 16'h0000;
    r.dma_base      = {space_img[{fn1, OFF_DMAB_HI}], 8'h00};
    r.dma_decode_on = onboard_en && cmd[0] && cmd[2];
    return r;
  endfunction

  task automatic push_access(logic [0:0] op, logic [2:0] fn, logic [7:0] ofs,
                             logic [7:0] data);
    dfcs_item_t a;
    a.opcode          = op;
    a.function_number = fn;
    a.offset          = ofs;
    a.write_byte      = data;
    access_q.push_back(a);
  endtask

  task automatic queue_random(int unsigned n);
    dfcs_item_t  a;
    int unsigned pick;
    for (int unsigned i = 0; i < n; i++) begin
      a.opcode = ($urandom_range(1, 0) == 0) ? OP_READ : OP_WRITE;
      a.function_number = ($urandom_range(9, 0) < 8) ? 3'($urandom_range(1, 0))
                                                     : 3'($urandom_range(7, 2));
      pick = $urandom_range(9, 0);
      if (pick < 4) begin
        case ($urandom_range(13, 0))
          0:       a.offset = OFF_CMD;
          1:       a.offset = OFF_CMD_HI;
          2:       a.offset = OFF_STATUS_HI;
          3:       a.offset = OFF_CMDB_LO;
          4:       a.offset = OFF_CMDB_HI;
          5:       a.offset = OFF_CTLP_LO;
          6:       a.offset = OFF_CTLP_HI;
          7:       a.offset = OFF_DMAB_LO;
          8:       a.offset = OFF_DMAB_HI;
          9:       a.offset = OFF_ROM_0;
          10:      a.offset = OFF_ROM_2;
          11:      a.offset = OFF_ROM_3;
          12:      a.offset = OFF_CHAN_EN;
          default: a.offset = OFF_TIMING;
        endcase
      end else if (pick < 5) begin
        a.offset = OFF_CHAN_EN + 8'($urandom_range(10, 0));
      end else begin
        a.offset = 8'($urandom_range(255, 0));
      end
      a.write_byte = 8'($urandom_range(255, 0));
      access_q.push_back(a);
    end
  endtask

  // nothing queued, nothing on the bus, nothing outstanding
  task automatic wait_drained();
    while (access_q.size() != 0 || s_axis_tvalid || due_results.size() != 0 ||
           s_axis_tready !== 1'b1)
      @(posedge clk_i);
  endtask

  task automatic set_onboard(logic en);
    wait_drained();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_wdata_i <= en;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LimitCycles) begin
      $display("status: fail");
      $finish;
    end
  end

  // sender: holds an offered transaction until taken, random idle bursts between
  always @(negedge clk_i) begin : sender
    dfcs_item_t nxt;
    if (rst_ni) begin
      if (s_axis_tvalid && !accepted) begin
        // still waiting for tready
      end else if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (access_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
        send_gap = $urandom_range(14, 1) - 1;
        s_axis_tvalid <= 1'b0;
      end else begin
        nxt = access_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, nxt.write_byte, nxt.offset, nxt.function_number};
        s_axis_tuser  <= nxt.opcode;
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  always @(negedge clk_i) begin : receiver
    if (hold_armed) begin
      hold_armed = 1'b0;
      hold_left  = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      m_axis_tready <= 1'b0;
    end else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
      recv_stall = $urandom_range(14, 1) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : monitor
    dfcs_item_t     got_in;
    decode_result_t seen;
    decode_result_t want;
    if (!rst_ni) begin
      accepted = 1'b0;
    end else begin
      if (cfg_we_i) onboard_en = cfg_wdata_i;
      accepted = s_axis_tvalid && s_axis_tready;
      if (accepted) begin
        got_in.opcode          = s_axis_tuser;
        got_in.function_number = s_axis_tdata[2:0];
        got_in.offset          = s_axis_tdata[10:3];
        got_in.write_byte      = s_axis_tdata[18:11];
        due_results.push_back(cfgspace_access(got_in));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen.read_byte         = m_axis_tdata[7:0];
        seen.command_base      = m_axis_tdata[23:8];
        seen.control_port      = m_axis_tdata[39:24];
        seen.channel_decode_on = m_axis_tdata[40];
        seen.dma_base          = m_axis_tdata[56:41];
        seen.dma_decode_on     = m_axis_tdata[57];
        if (due_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MaxShown)
            $display("result transaction with none outstanding: %h", m_axis_tdata);
        end else begin
          want = due_results.pop_front();
          if (seen.read_byte !== want.read_byte ||
              seen.command_base !== want.command_base ||
              seen.control_port !== want.control_port ||
              seen.channel_decode_on !== want.channel_decode_on ||
              seen.dma_base !== want.dma_base ||
              seen.dma_decode_on !== want.dma_decode_on) begin
            err_cnt++;
            if (err_cnt <= MaxShown)
              $display({"mismatch: expected rd %h cmdb %h ctlp %h chon %b dmab %h dmon %b,",
                        " got rd %h cmdb %h ctlp %h chon %b dmab %h dmon %b"},
                       want.read_byte, want.command_base, want.control_port,
                       want.channel_decode_on, want.dma_base, want.dma_decode_on,
                       seen.read_byte, seen.command_base, seen.control_port,
                       seen.channel_decode_on, seen.dma_base, seen.dma_decode_on);
          end
        end
      end
    end
  end

  initial begin : stimulus
    logic fb;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;

    // power-on contents of both functions
    for (int i = 0; i < 512; i++) space_img[i] = 8'h00;
    for (int f = 0; f < 2; f++) begin
      fb = f[0];
      space_img[{fb, 8'h00}] = 8'h03;
      space_img[{fb, 8'h01}] = 8'h11;
      space_img[{fb, 8'h02}] = 8'h04;
      space_img[{fb, OFF_STATUS_HI}] = 8'h02;
      space_img[{fb, 8'h08}] = 8'h01;
      space_img[{fb, 8'h0a}] = 8'h80;
      space_img[{fb, 8'h0b}] = 8'h01;
      space_img[{fb, 8'h0e}] = 8'h80;
      space_img[{fb, OFF_CMDB_LO}] = 8'h01;
      space_img[{fb, OFF_CTLP_LO}] = 8'h01;
      space_img[{fb, OFF_DMAB_LO}] = 8'h01;
      space_img[{fb, 8'h2c}] = 8'h03;
      space_img[{fb, 8'h2d}] = 8'h11;
      space_img[{fb, 8'h2e}] = 8'h04;
      space_img[{fb, OFF_IRQ_PIN}] = fb ? 8'h02 : 8'h01;
      space_img[{fb, 8'h40}] = 8'ha7;
      space_img[{fb, 8'h41}] = 8'ha7;
      space_img[{fb, 8'h42}] = 8'h20;
      space_img[{fb, 8'h43}] = 8'h01;
      space_img[{fb, 8'h44}] = 8'ha7;
      space_img[{fb, 8'h45}] = 8'ha7;
      space_img[{fb, 8'h46}] = 8'h20;
      space_img[{fb, 8'h47}] = 8'h01;
      space_img[{fb, OFF_CHAN_EN}] = 8'h30;
    end
    onboard_en = 1'b1;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: absent functions, masks, write-one-to-clear, rom bytes, shared bytes
    idle_odds = 6;
    set_onboard(1'b1);
    push_access(OP_READ,  3'd0, 8'h00,         8'h00);
    push_access(OP_READ,  3'd1, OFF_IRQ_PIN,   8'hff);
    push_access(OP_READ,  3'd7, 8'hff,         8'h00);
    push_access(OP_WRITE, 3'd2, OFF_CMD,       8'hff);
    push_access(OP_WRITE, 3'd0, OFF_CMD,       8'hff);
    push_access(OP_WRITE, 3'd0, OFF_CMD_HI,    8'hff);
    push_access(OP_WRITE, 3'd0, OFF_STATUS_HI, 8'hff);
    push_access(OP_WRITE, 3'd0, OFF_CMDB_LO,   8'hff);
    push_access(OP_WRITE, 3'd0, OFF_CMDB_HI,   8'hff);
    push_access(OP_WRITE, 3'd0, OFF_CTLP_LO,   8'h00);
    push_access(OP_WRITE, 3'd0, OFF_CTLP_HI,   8'hff);
    push_access(OP_WRITE, 3'd0, OFF_DMAB_LO,   8'h55);
    push_access(OP_WRITE, 3'd0, OFF_DMAB_HI,   8'hff);
    push_access(OP_WRITE, 3'd0, OFF_ROM_0,     8'hff);
    push_access(OP_READ,  3'd0, OFF_ROM_2,     8'h00);
    push_access(OP_WRITE, 3'd1, OFF_ROM_0,     8'hff);
    push_access(OP_WRITE, 3'd1, OFF_ROM_3,     8'hff);
    push_access(OP_WRITE, 3'd0, OFF_ROM_2,     8'hff);
    push_access(OP_WRITE, 3'd1, OFF_CHAN_EN,   8'hff);
    push_access(OP_READ,  3'd0, OFF_CHAN_EN,   8'h00);
    push_access(OP_WRITE, 3'd0, OFF_TIMING,    8'hff);
    push_access(OP_WRITE, 3'd1, 8'h5a,         8'h00);
    push_access(OP_WRITE, 3'd1, 8'hff,         8'ha5);
    push_access(OP_WRITE, 3'd0, 8'h00,         8'h5a);
    push_access(OP_WRITE, 3'd1, OFF_CMD,       8'h05);

    set_onboard(1'b0);
    idle_odds = 5;
    queue_random(300);

    // long receiver hold-off while the sender keeps offering
    set_onboard(1'b1);
    idle_odds  = 3;
    hold_armed = 1'b1;
    queue_random(300);

    set_onboard(1'b0);
    idle_odds = 8;
    queue_random(250);

    // closing stretch runs at full rate
    set_onboard(1'b1);
    idle_odds = 0;
    queue_random(300);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0 && due_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/dfcs_pkg.sv
hw/rtl/dfcs_ram.sv
hw/rtl/dual_function_ide_pci_config_space_core.sv
tb/dual_function_ide_pci_config_space_core_test.sv
